// ===== hdl/ssvg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvg_pkg
// Shared types and constants of the sphere strip vertex generator.
// ----------------------------------------------------------------------------
package ssvg_pkg;

    localparam int PHASE_W  = 16;   // angle phase, 1/65536 turn
    localparam int CRD_W    = 16;   // center coordinate
    localparam int RAD_W    = 12;   // radius
    localparam int SEG_W    = 8;    // segment count
    localparam int POS_W    = 17;   // vertex position
    localparam int NORM_W   = 16;   // Q1.14 normal component
    localparam int VNUM_W   = 14;   // running vertex index
    localparam int TDATA_W  = 120;  // output beat, whole bytes
    localparam int PAD_W    = TDATA_W - 3 * POS_W - 3 * NORM_W - VNUM_W;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [NORM_W-1:0]  Q14_ONE      = 16'sd16384;

    // descriptor kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_NORTH = 2'd1;
    localparam logic [1:0] KIND_SOUTH = 2'd2;
    localparam logic [1:0] KIND_BODY  = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // one classified vertex request
    typedef struct packed {
        logic [1:0]         kind;
        logic [PHASE_W-1:0] zt;      // polar phase
        logic [PHASE_W-1:0] az;      // azimuth phase
        logic [VNUM_W-1:0]  vnum;
        logic               last;
    } t_desc;

    // sphere geometry used by the datapath
    typedef struct packed {
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic signed [CRD_W-1:0] cz;
        logic [RAD_W-1:0]        radius;
    } t_geom;

endpackage

// ===== hdl/ssvg_sine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvg_sine
// Quarter-wave sine ROM lookup with registered Q1.14 result.
// ----------------------------------------------------------------------------
module ssvg_sine import ssvg_pkg::*; #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic signed [NORM_W-1:0] o_sin
);

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = $clog2(N + 1);
    localparam int PW = 14 + IW;

    logic [14:0]         w_rom [0:N];
    logic [1:0]          w_quad;
    logic [PW-1:0]       w_prod;
    logic [IW-1:0]       w_raw;
    logic [IW-1:0]       w_clip;
    logic [IW-1:0]       w_idx;
    logic [NORM_W-1:0]   w_mag;
    logic signed [NORM_W-1:0] r_sin;

    // ROM contents: integer Taylor series of sin in Q4.28, rounded to Q1.14
    for (genvar k = 0; k <= N; k++) begin : g_rom
        localparam longint unsigned X  = (64'd421657428 * k + N / 2) / N;
        localparam longint unsigned X2 = (X * X) >> 28;
        localparam longint unsigned T1 = ((X  * X2) >> 28) / 6;
        localparam longint unsigned T2 = ((T1 * X2) >> 28) / 20;
        localparam longint unsigned T3 = ((T2 * X2) >> 28) / 42;
        localparam longint unsigned T4 = ((T3 * X2) >> 28) / 72;
        localparam longint unsigned T5 = ((T4 * X2) >> 28) / 110;
        localparam longint unsigned T6 = ((T5 * X2) >> 28) / 156;
        localparam longint unsigned T7 = ((T6 * X2) >> 28) / 210;
        localparam longint unsigned T8 = ((T7 * X2) >> 28) / 272;
        localparam longint unsigned T9 = ((T8 * X2) >> 28) / 342;
        localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
                               - longint'(T3) + longint'(T4) - longint'(T5)
                               + longint'(T6) - longint'(T7) + longint'(T8)
                               - longint'(T9);
        localparam longint SPOS = (SUM < 0) ? 0 : SUM;
        localparam longint Q    = (SPOS * 16384 + (longint'(1) << 27)) >>> 28;
        localparam longint QC   = (Q > 16384) ? 16384 : Q;
        assign w_rom[k] = 15'(QC);
    end

    assign w_quad = i_phase[15:14];
    assign w_prod = PW'(i_phase[13:0]) * PW'(N) + PW'(8192);
    assign w_raw  = w_prod[PW-1:14];
    assign w_clip = (w_raw > IW'(N)) ? IW'(N) : w_raw;
    // odd quadrants run the table backwards
    assign w_idx  = w_quad[0] ? (IW'(N) - w_clip) : w_clip;
    assign w_mag  = {1'b0, w_rom[w_idx]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= w_quad[1] ? (NORM_W'(0) - w_mag) : w_mag;
        end
    end

    assign o_sin = r_sin;

endmodule

// ===== hdl/ssvg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvg_queue
// Two-entry descriptor queue between the walk front and the datapath.
// ----------------------------------------------------------------------------
module ssvg_queue import ssvg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    output logic  o_valid,
    output t_desc o_desc,
    input  logic  i_pop
);

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? (r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop ? (r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count + (QPTR_W + 1)'(w_push) - (QPTR_W + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== hdl/ssvg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvg_front
// Strip walk: takes requests, advances the vertex counters, emits descriptors.
// ----------------------------------------------------------------------------
module ssvg_front import ssvg_pkg::*; #(
    parameter int MAX_SEGMENTS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_restart,
    input  logic               i_q_ready,
    input  logic [SEG_W-1:0]   i_segments,
    input  logic [PHASE_W-1:0] i_angle_step,
    output logic               o_ready,
    output logic               o_push,
    output t_desc              o_desc
);

    localparam int H_MAX     = MAX_SEGMENTS / 2;
    localparam int TOTAL_MAX = H_MAX * (4 * H_MAX - 2) - 1;
    localparam int CNT_W     = $clog2(TOTAL_MAX + 1);
    localparam int RING_W    = $clog2(H_MAX + 1);
    // phi = 2*step*strip wraps at one turn, so strip modulo 2^15 is enough
    localparam int STRIP_W   = 15;

    localparam logic [1:0] SEC_NORTH = 2'd0;
    localparam logic [1:0] SEC_DESC  = 2'd1;
    localparam logic [1:0] SEC_SOUTH = 2'd2;
    localparam logic [1:0] SEC_ASC   = 2'd3;

    logic [STRIP_W-1:0] r_strip, n_strip, e_strip;
    logic [RING_W-1:0]  r_ring, n_ring, e_ring;
    logic [1:0]         r_sec, n_sec, e_sec;
    logic               r_pair, n_pair, e_pair;
    logic [CNT_W-1:0]   r_cnt, n_cnt, e_cnt;
    logic               r_fin, n_fin, e_fin;

    logic                    w_seg_ok;
    logic [SEG_W-2:0]        w_h;
    logic [7:0]              w_h8;
    logic [15:0]             w_prod;
    logic [CNT_W-1:0]        w_total;
    logic                    w_none;
    logic                    w_last;
    logic [30:0]             w_phi_prod;
    logic [PHASE_W-1:0]      w_phi;
    logic [RING_W:0]         w_ring1;
    logic [PHASE_W-1:0]      w_zt;
    logic [PHASE_W-1:0]      w_az;
    logic [RING_W-1:0]       w_ring_inc;
    logic [31:0]             w_cnt32;
    t_desc                   w_desc;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;
    assign o_desc  = w_desc;

    // list length for the current segment count
    assign w_seg_ok = (i_segments != '0) && !i_segments[0]
                   && ({1'b0, i_segments} <= 9'(MAX_SEGMENTS));
    assign w_h      = i_segments[SEG_W-1:1];
    assign w_h8     = 8'(w_h);
    assign w_prod   = 16'(w_h) * (16'({w_h, 2'b00}) - 16'd2);
    assign w_total  = w_seg_ok ? CNT_W'(w_prod - 16'd1) : '0;

    // state as seen by this request, after an optional restart
    assign e_strip = i_restart ? '0 : r_strip;
    assign e_ring  = i_restart ? '0 : r_ring;
    assign e_sec   = i_restart ? SEC_NORTH : r_sec;
    assign e_pair  = i_restart ? 1'b0 : r_pair;
    assign e_cnt   = i_restart ? '0 : r_cnt;
    assign e_fin   = i_restart ? 1'b0 : r_fin;

    assign w_none  = e_fin || (e_cnt >= w_total);
    assign w_last  = (({1'b0, e_cnt} + 1'b1) == {1'b0, w_total});
    assign w_cnt32 = 32'(e_cnt);

    // phases of this vertex
    assign w_phi_prod = 31'(i_angle_step) * 31'(e_strip);
    assign w_phi      = {w_phi_prod[14:0], 1'b0};
    assign w_ring1    = (RING_W + 1)'(e_ring) + 1'b1;
    assign w_zt       = 16'(i_angle_step * 16'(w_ring1));
    assign w_ring_inc = e_ring + 1'b1;

    always_comb begin
        if (e_pair) begin
            w_az = w_phi + i_angle_step;
        end else if (e_sec == SEC_DESC) begin
            w_az = w_phi;
        end else begin
            w_az = w_phi + {i_angle_step[14:0], 1'b0};
        end
    end

    always_comb begin
        w_desc      = '0;
        n_strip     = e_strip;
        n_ring      = e_ring;
        n_sec       = e_sec;
        n_pair      = e_pair;
        n_cnt       = e_cnt;
        n_fin       = 1'b1;
        if (!w_none) begin
            w_desc.zt   = w_zt;
            w_desc.az   = w_az;
            w_desc.vnum = w_cnt32[VNUM_W-1:0];
            w_desc.last = w_last;
            n_cnt       = e_cnt + 1'b1;
            n_fin       = w_last;
            unique case (e_sec)
                SEC_NORTH: begin
                    w_desc.kind = KIND_NORTH;
                    n_sec       = (w_h < 7'd2) ? SEC_SOUTH : SEC_DESC;
                    n_ring      = '0;
                    n_pair      = 1'b0;
                end
                SEC_DESC: begin
                    w_desc.kind = KIND_BODY;
                    if (!e_pair) begin
                        n_pair = 1'b1;
                    end else begin
                        n_pair = 1'b0;
                        n_ring = w_ring_inc;
                        if ((8'(w_ring_inc) + 8'd1) >= w_h8) begin
                            n_sec = SEC_SOUTH;
                        end
                    end
                end
                SEC_SOUTH: begin
                    w_desc.kind = KIND_SOUTH;
                    if (w_h < 7'd2) begin
                        n_strip = e_strip + 1'b1;
                        n_sec   = SEC_NORTH;
                        n_ring  = '0;
                    end else begin
                        n_sec  = SEC_ASC;
                        n_ring = RING_W'(w_h8 - 8'd2);
                        n_pair = 1'b0;
                    end
                end
                default: begin
                    w_desc.kind = KIND_BODY;
                    if (!e_pair) begin
                        n_pair = 1'b1;
                    end else begin
                        n_pair = 1'b0;
                        if (e_ring == '0) begin
                            n_strip = e_strip + 1'b1;
                            n_sec   = SEC_NORTH;
                        end else begin
                            n_ring = e_ring - 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= '0;
            r_ring  <= '0;
            r_sec   <= SEC_NORTH;
            r_pair  <= 1'b0;
            r_cnt   <= '0;
            r_fin   <= 1'b1;
        end else if (o_push) begin
            r_strip <= n_strip;
            r_ring  <= n_ring;
            r_sec   <= n_sec;
            r_pair  <= n_pair;
            r_cnt   <= n_cnt;
            r_fin   <= n_fin;
        end
    end

`ifndef SYNTHESIS
    a_fin_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !i_restart && r_fin) |-> (o_desc.kind == KIND_NONE))
        else $error("request after end of list produced a vertex");

    a_last_sets_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_desc.last) |=> r_fin)
        else $error("walk not finished after last vertex");

    a_pair_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair |-> (r_sec == SEC_DESC || r_sec == SEC_ASC))
        else $error("pair member set outside ring sections");
`endif

endmodule

// ===== hdl/ssvg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssvg_back
// Vertex datapath: sine lookups, products, rounding, center offset, output.
// ----------------------------------------------------------------------------
module ssvg_back import ssvg_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_desc              i_desc,
    output logic               o_q_ready,
    input  t_geom              i_geom,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,  // pos_x, pos_y, pos_z, norm_x,
                                           // norm_y, norm_z, vertex_number
    output logic               o_m_tlast,
    output logic               o_m_tuser   // none_left
);

    localparam int T_W   = 28;  // radius * sin
    localparam int P_W   = 30;  // Q1.14 * Q1.14
    localparam int Q_W   = 41;  // radius * sin * sin
    localparam int OFF_W = 13;  // rounded position offset

    logic w_adv;

    // stage 1: sine lookups
    logic signed [NORM_W-1:0] w_sz, w_cz, w_sa, w_ca;
    logic [PHASE_W-1:0]       w_zt_cos, w_az_cos;
    logic                     r1_v;
    logic [1:0]               r1_kind;
    logic [VNUM_W-1:0]        r1_vnum;
    logic                     r1_last;

    // stage 2: first products
    logic                     r2_v;
    logic [1:0]               r2_kind;
    logic [VNUM_W-1:0]        r2_vnum;
    logic                     r2_last;
    logic signed [T_W-1:0]    r2_t, r2_pcy;
    logic signed [P_W-1:0]    r2_psa, r2_pca;
    logic signed [NORM_W-1:0] r2_sa, r2_ca, r2_cz;
    logic signed [RAD_W:0]    w_rad_s;

    // stage 3: second products
    logic                     r3_v;
    logic [1:0]               r3_kind;
    logic [VNUM_W-1:0]        r3_vnum;
    logic                     r3_last;
    logic signed [Q_W-1:0]    r3_qx, r3_qz;
    logic signed [P_W-1:0]    r3_psa, r3_pca;
    logic signed [T_W-1:0]    r3_pcy;
    logic signed [NORM_W-1:0] r3_cz;

    // stage 4: rounding
    logic                     r4_v;
    logic [1:0]               r4_kind;
    logic [VNUM_W-1:0]        r4_vnum;
    logic                     r4_last;
    logic signed [NORM_W-1:0] r4_nx, r4_ny, r4_nz;
    logic signed [OFF_W-1:0]  r4_ox, r4_oy, r4_oz;
    logic [P_W:0]             w_nx_sum, w_nz_sum;
    logic [Q_W:0]             w_ox_sum, w_oz_sum;
    logic [T_W:0]             w_oy_sum;

    // output register
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_px, r_py, r_pz, n_px, n_py, n_pz;
    logic [NORM_W-1:0]        r_nx, r_ny, r_nz, n_nx, n_ny, n_nz;
    logic [VNUM_W-1:0]        r_vnum, n_vnum;
    logic                     r_last, n_last;
    logic                     r_none, n_none;

    // whole pipe moves together unless the output beat is held
    assign w_adv     = !r_out_valid || i_m_tready;
    assign o_q_ready = w_adv;

    assign w_zt_cos = i_desc.zt + QUARTER_TURN;
    assign w_az_cos = i_desc.az + QUARTER_TURN;

    ssvg_sine #(.TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sin_zt (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (i_desc.zt),
        .o_sin   (w_sz)
    );

    ssvg_sine #(.TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_cos_zt (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_zt_cos),
        .o_sin   (w_cz)
    );

    ssvg_sine #(.TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sin_az (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (i_desc.az),
        .o_sin   (w_sa)
    );

    ssvg_sine #(.TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_cos_az (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_phase (w_az_cos),
        .o_sin   (w_ca)
    );

    assign w_rad_s = $signed({1'b0, i_geom.radius});

    // round half away from zero: (v + half - (v < 0)) >> s
    assign w_nx_sum = (P_W + 1)'(r3_psa) + (P_W + 1)'(32'd8192)
                    - (P_W + 1)'(r3_psa[P_W-1]);
    assign w_nz_sum = (P_W + 1)'(r3_pca) + (P_W + 1)'(32'd8192)
                    - (P_W + 1)'(r3_pca[P_W-1]);
    assign w_ox_sum = (Q_W + 1)'(r3_qx) + (Q_W + 1)'(32'd134217728)
                    - (Q_W + 1)'(r3_qx[Q_W-1]);
    assign w_oz_sum = (Q_W + 1)'(r3_qz) + (Q_W + 1)'(32'd134217728)
                    - (Q_W + 1)'(r3_qz[Q_W-1]);
    assign w_oy_sum = (T_W + 1)'(r3_pcy) + (T_W + 1)'(32'd8192)
                    - (T_W + 1)'(r3_pcy[T_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_v        <= i_q_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r_out_valid <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_kind <= i_desc.kind;
            r1_vnum <= i_desc.vnum;
            r1_last <= i_desc.last;

            r2_kind <= r1_kind;
            r2_vnum <= r1_vnum;
            r2_last <= r1_last;
            r2_t    <= T_W'(w_rad_s) * T_W'(w_sz);
            r2_pcy  <= T_W'(w_rad_s) * T_W'(w_cz);
            r2_psa  <= P_W'(w_sz) * P_W'(w_sa);
            r2_pca  <= P_W'(w_sz) * P_W'(w_ca);
            r2_sa   <= w_sa;
            r2_ca   <= w_ca;
            r2_cz   <= w_cz;

            r3_kind <= r2_kind;
            r3_vnum <= r2_vnum;
            r3_last <= r2_last;
            r3_qx   <= Q_W'(r2_t) * Q_W'(r2_sa);
            r3_qz   <= Q_W'(r2_t) * Q_W'(r2_ca);
            r3_psa  <= r2_psa;
            r3_pca  <= r2_pca;
            r3_pcy  <= r2_pcy;
            r3_cz   <= r2_cz;

            r4_kind <= r3_kind;
            r4_vnum <= r3_vnum;
            r4_last <= r3_last;
            r4_nx   <= w_nx_sum[29:14];
            r4_nz   <= w_nz_sum[29:14];
            r4_ny   <= r3_cz;
            r4_ox   <= w_ox_sum[40:28];
            r4_oz   <= w_oz_sum[40:28];
            r4_oy   <= w_oy_sum[26:14];

            r_px    <= n_px;
            r_py    <= n_py;
            r_pz    <= n_pz;
            r_nx    <= n_nx;
            r_ny    <= n_ny;
            r_nz    <= n_nz;
            r_vnum  <= n_vnum;
            r_last  <= n_last;
            r_none  <= n_none;
        end
    end

    always_comb begin
        n_px   = POS_W'(i_geom.cx);
        n_py   = POS_W'(i_geom.cy);
        n_pz   = POS_W'(i_geom.cz);
        n_nx   = '0;
        n_ny   = '0;
        n_nz   = '0;
        n_vnum = r4_vnum;
        n_last = r4_last;
        n_none = 1'b0;
        case (r4_kind)
            KIND_NONE: begin
                n_px   = '0;
                n_py   = '0;
                n_pz   = '0;
                n_vnum = '0;
                n_last = 1'b0;
                n_none = 1'b1;
            end
            KIND_NORTH: begin
                n_py = POS_W'(i_geom.cy) + POS_W'(i_geom.radius);
                n_ny = Q14_ONE;
            end
            KIND_SOUTH: begin
                n_py = POS_W'(i_geom.cy) - POS_W'(i_geom.radius);
                n_ny = NORM_W'(0) - Q14_ONE;
            end
            default: begin
                n_px = POS_W'(i_geom.cx) + POS_W'(r4_ox);
                n_py = POS_W'(i_geom.cy) + POS_W'(r4_oy);
                n_pz = POS_W'(i_geom.cz) + POS_W'(r4_oz);
                n_nx = r4_nx;
                n_ny = r4_ny;
                n_nz = r4_nz;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {PAD_W'(0), r_vnum, r_nz, r_ny, r_nx, r_pz, r_py, r_px};
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_none;

endmodule

// ===== hdl/sphere_strip_vertex_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_strip_vertex_generator_unit
// UV sphere vertices in triangle-strip order, one vertex beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave beat is a request; tdata[0] set restarts the list at vertex 0,
//   clear asks for the next vertex. Every request yields exactly one master
//   beat: position, Q1.14 normal and running index in tdata, tlast on the
//   final vertex of the list, tuser set when no vertex is left (list done,
//   or segments odd, zero or above MAX_SEGMENTS).
//   The APB port sets center, radius, segments and angle step; change it
//   only while no request is in flight.
// Timing:
//   A request passes a queue stage, the sine ROM read, two multiply stages,
//   a rounding stage and the output register on its way to the master side.
//   One beat per cycle is sustained while the master takes beats; the walk
//   counters take one request per cycle and the datapath is fully pipelined.
// Reset and stall:
//   Reset loads the register defaults and leaves the walk finished, so
//   requests give tuser beats until a restart. When the master side stalls,
//   the datapath holds, the two-entry queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module sphere_strip_vertex_generator_unit import ssvg_pkg::*; #(
    parameter int MAX_SEGMENTS       = 128,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // restart
    // vertex stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // pos_x, pos_y, pos_z, norm_x,
                                            // norm_y, norm_z, vertex_number
    output logic               o_m_tlast,   // last_vertex
    output logic               o_m_tuser,   // none_left
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_Z   = 3'd2;
    localparam logic [2:0] REG_RADIUS     = 3'd3;
    localparam logic [2:0] REG_SEGMENTS   = 3'd4;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd5;

    logic signed [CRD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [RAD_W-1:0]        r_radius;
    logic [SEG_W-1:0]        r_segments;
    logic [PHASE_W-1:0]      r_angle_step;

    logic [2:0] w_reg_idx;
    logic       w_wr;
    t_geom      w_geom;

    logic  w_f_push;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_q_pop;
    t_desc w_f_desc;
    t_desc w_q_desc;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[4:2];
    assign w_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_center_z   <= '0;
            r_radius     <= 12'd20;
            r_segments   <= 8'd100;
            r_angle_step <= 16'd655;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_CENTER_X:   r_center_x   <= pwdata[CRD_W-1:0];
                REG_CENTER_Y:   r_center_y   <= pwdata[CRD_W-1:0];
                REG_CENTER_Z:   r_center_z   <= pwdata[CRD_W-1:0];
                REG_RADIUS:     r_radius     <= pwdata[RAD_W-1:0];
                REG_SEGMENTS:   r_segments   <= pwdata[SEG_W-1:0];
                REG_ANGLE_STEP: r_angle_step <= pwdata[PHASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CENTER_X:   prdata = 32'(r_center_x);
            REG_CENTER_Y:   prdata = 32'(r_center_y);
            REG_CENTER_Z:   prdata = 32'(r_center_z);
            REG_RADIUS:     prdata = 32'(r_radius);
            REG_SEGMENTS:   prdata = 32'(r_segments);
            REG_ANGLE_STEP: prdata = 32'(r_angle_step);
            default:        prdata = '0;
        endcase
    end

    assign w_geom.cx     = r_center_x;
    assign w_geom.cy     = r_center_y;
    assign w_geom.cz     = r_center_z;
    assign w_geom.radius = r_radius;

    ssvg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_restart    (i_s_tdata[0]),
        .i_q_ready    (w_q_ready),
        .i_segments   (r_segments),
        .i_angle_step (r_angle_step),
        .o_ready      (o_s_tready),
        .o_push       (w_f_push),
        .o_desc       (w_f_desc)
    );

    ssvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_desc  (w_f_desc),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_desc  (w_q_desc),
        .i_pop   (w_q_pop)
    );

    ssvg_back #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_desc     (w_q_desc),
        .o_q_ready  (w_q_pop),
        .i_geom     (w_geom),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
